/* hw/rtl/qdsm_pkg.sv */
// Package with the shared widths, reset values and item codes of the quadrature decoder.
package qdsm_pkg;

    // Fixed field widths of the ports.
    localparam int SCALE_W    = 16;
    localparam int POSITION_W = 16;
    localparam int SPEED_W    = 33;
    localparam int CHANNEL_W  = 1;

    // Reset value of the speed scale register (Q8.8).
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2513;

    // Defaults of the top level parameters.
    localparam int NUM_CHANNELS_DEFAULT = 2;
    localparam int COUNT_WIDTH_DEFAULT  = 16;

    // Item kinds carried on the mode field.
    localparam logic MODE_PIN  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Step direction codes.
    localparam logic DIR_DOWN = 1'b0;
    localparam logic DIR_UP   = 1'b1;

endpackage

/* hw/rtl/quadrature_decoder_speed_meter.sv */
// Quadrature x4 decoder with per-channel position counters and tick-based speed measurement.
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_ready    mode, channel, pin_a, pin_b
//  result    out        out_valid / out_ready  position, direction, speed, speed_valid
//  config    in         speed_scale_we         speed_scale_wdata
//
// Every transfer is processed combinationally between the input register and the result
// register, so one item per clock is sustained while the result channel is not stalled.
// The single 16 x COUNT_WIDTH multiply of the tick path sets the clock-to-clock path.
// Reset clears all channel state and loads the speed scale with its default value.
// A stalled result holds in the result register; the input register still accepts
// a transfer while the result register is empty or being drained.
module quadrature_decoder_speed_meter #(
    parameter int NUM_CHANNELS = qdsm_pkg::NUM_CHANNELS_DEFAULT,
    parameter int COUNT_WIDTH  = qdsm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write port
    input  logic                                speed_scale_we,
    input  logic [qdsm_pkg::SCALE_W-1:0]        speed_scale_wdata,

    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [qdsm_pkg::CHANNEL_W-1:0]      channel,
    input  logic                                pin_a,
    input  logic                                pin_b,

    // Result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [qdsm_pkg::POSITION_W-1:0]     position,
    output logic                                direction,
    output logic signed [qdsm_pkg::SPEED_W-1:0] speed,
    output logic                                speed_valid
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W   = COUNT_WIDTH + qdsm_pkg::SCALE_W;
    localparam int PROD_X_W = (PROD_W > qdsm_pkg::SPEED_W) ? PROD_W : qdsm_pkg::SPEED_W;
    localparam int POS_X_W  = (COUNT_WIDTH > qdsm_pkg::POSITION_W) ?
                              COUNT_WIDTH : qdsm_pkg::POSITION_W;

    // Configuration register
    logic [qdsm_pkg::SCALE_W-1:0] scale_reg;

    // Per-channel state
    logic                   last_a_reg   [NUM_CHANNELS];
    logic                   last_b_reg   [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] count_reg    [NUM_CHANNELS];
    logic                   dir_reg      [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] snapshot_reg [NUM_CHANNELS];

    // Input register
    logic                           s1_valid_reg;
    logic                           s1_mode_reg;
    logic [qdsm_pkg::CHANNEL_W-1:0] s1_channel_reg;
    logic                           s1_a_reg;
    logic                           s1_b_reg;

    // Result register
    logic                                out_valid_reg;
    logic [qdsm_pkg::POSITION_W-1:0]     position_reg;
    logic                                direction_reg;
    logic signed [qdsm_pkg::SPEED_W-1:0] speed_reg;
    logic                                speed_valid_reg;

    // Combinational results of the processing step
    logic                                advance;
    logic                                ch_ok;
    logic [CH_IDX_W-1:0]                 ch_idx;
    logic                                cur_a;
    logic                                cur_b;
    logic [COUNT_WIDTH-1:0]              cur_count;
    logic                                cur_dir;
    logic [COUNT_WIDTH-1:0]              cur_snap;
    logic                                a_changed;
    logic                                b_changed;
    logic                                a_down;
    logic                                b_down;
    logic [COUNT_WIDTH-1:0]              count_after_a;
    logic [COUNT_WIDTH-1:0]              count_next;
    logic                                dir_next;
    logic [COUNT_WIDTH-1:0]              diff;
    logic [PROD_W-1:0]                   product;
    logic [PROD_X_W-1:0]                 product_x;
    logic [qdsm_pkg::SPEED_W-1:0]        magnitude;
    logic [POS_X_W-1:0]                  count_x;
    logic                                is_tick;
    logic                                pin_item;
    logic [qdsm_pkg::POSITION_W-1:0]     position_next;
    logic                                direction_next;
    logic signed [qdsm_pkg::SPEED_W-1:0] speed_next;
    logic                                speed_valid_next;

    // Handshake: the input register moves on whenever the result register can take it.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    // Channel selection and read of the stored state.
    always_comb
    begin
        ch_ok  = (32'(s1_channel_reg) < 32'(NUM_CHANNELS));
        ch_idx = ch_ok ? CH_IDX_W'(s1_channel_reg) : '0;
        cur_a     = last_a_reg[ch_idx];
        cur_b     = last_b_reg[ch_idx];
        cur_count = count_reg[ch_idx];
        cur_dir   = dir_reg[ch_idx];
        cur_snap  = snapshot_reg[ch_idx];
    end

    // x4 decoding: the A step is applied first, then the B step.
    always_comb
    begin
        a_changed = (s1_a_reg != cur_a);
        b_changed = (s1_b_reg != cur_b);
        a_down    = (s1_a_reg == s1_b_reg);
        b_down    = (s1_a_reg != s1_b_reg);

        count_after_a = cur_count;
        if (a_changed)
        begin
            count_after_a = a_down ? cur_count - COUNT_WIDTH'(1) : cur_count + COUNT_WIDTH'(1);
        end

        count_next = count_after_a;
        if (b_changed)
        begin
            count_next = b_down ? count_after_a - COUNT_WIDTH'(1)
                                : count_after_a + COUNT_WIDTH'(1);
        end

        if (b_changed)
        begin
            dir_next = b_down ? qdsm_pkg::DIR_DOWN : qdsm_pkg::DIR_UP;
        end
        else if (a_changed)
        begin
            dir_next = a_down ? qdsm_pkg::DIR_DOWN : qdsm_pkg::DIR_UP;
        end
        else
        begin
            dir_next = cur_dir;
        end
    end

    // Speed: travel since the last snapshot in the last direction, scaled.
    always_comb
    begin
        diff      = (cur_dir == qdsm_pkg::DIR_UP) ? cur_count - cur_snap : cur_snap - cur_count;
        product   = PROD_W'(diff) * PROD_W'(scale_reg);
        product_x = PROD_X_W'(product);
        magnitude = product_x[qdsm_pkg::SPEED_W-1:0];
    end

    // Result fields of the item in the input register.
    always_comb
    begin
        is_tick  = (s1_mode_reg == qdsm_pkg::MODE_TICK);
        pin_item = (s1_mode_reg == qdsm_pkg::MODE_PIN);

        if (!ch_ok)
        begin
            count_x = '0;
        end
        else if (pin_item)
        begin
            count_x = POS_X_W'(count_next);
        end
        else
        begin
            count_x = POS_X_W'(cur_count);
        end
        position_next = count_x[qdsm_pkg::POSITION_W-1:0];

        if (!ch_ok)
        begin
            direction_next = 1'b0;
        end
        else if (pin_item)
        begin
            direction_next = dir_next;
        end
        else
        begin
            direction_next = cur_dir;
        end

        if (ch_ok && is_tick)
        begin
            speed_next = (cur_dir == qdsm_pkg::DIR_UP) ? -$signed(magnitude)
                                                       : $signed(magnitude);
            speed_valid_next = 1'b1;
        end
        else
        begin
            speed_next       = '0;
            speed_valid_next = 1'b0;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= qdsm_pkg::SCALE_RESET;
        end
        else if (speed_scale_we)
        begin
            scale_reg <= speed_scale_wdata;
        end
    end

    // Channel state update when an item leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                last_a_reg[k]   <= 1'b0;
                last_b_reg[k]   <= 1'b0;
                count_reg[k]    <= '0;
                dir_reg[k]      <= qdsm_pkg::DIR_DOWN;
                snapshot_reg[k] <= '0;
            end
        end
        else if (s1_valid_reg && advance && ch_ok)
        begin
            if (pin_item)
            begin
                last_a_reg[ch_idx] <= s1_a_reg;
                last_b_reg[ch_idx] <= s1_b_reg;
                count_reg[ch_idx]  <= count_next;
                dir_reg[ch_idx]    <= dir_next;
            end
            else
            begin
                snapshot_reg[ch_idx] <= cur_count;
            end
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg    <= mode;
            s1_channel_reg <= channel;
            s1_a_reg       <= pin_a;
            s1_b_reg       <= pin_b;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            position_reg    <= position_next;
            direction_reg   <= direction_next;
            speed_reg       <= speed_next;
            speed_valid_reg <= speed_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = position_reg;
    assign direction   = direction_reg;
    assign speed       = speed_reg;
    assign speed_valid = speed_valid_reg;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the quadrature decoder with tick-based speed measurement.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // One result as it leaves the block.
    typedef struct packed {
        logic [qdsm_pkg::POSITION_W-1:0]     position;
        logic                                direction;
        logic signed [qdsm_pkg::SPEED_W-1:0] speed;
        logic                                speed_valid;
    } reading_t;

    // One row of the directed part: either an item or a speed scale write.
    typedef enum logic {ROW_ITEM, ROW_SCALE} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic                           mode;
        logic [qdsm_pkg::CHANNEL_W-1:0] chan;
        logic                           a;
        logic                           b;
        logic [qdsm_pkg::SCALE_W-1:0]   scale;
        logic                           typed;
        reading_t                       want;
    } stim_row_t;

    localparam reading_t NO_READING = '0;
    localparam int       DIR_ROWS   = 27;
    localparam int       PHASES     = 6;
    localparam int       PHASE_ITEMS = 138;

    // Directed part. Rows with typed results can be worked out by hand; the rest
    // are checked against the decoder model below.
    localparam stim_row_t dir_rows [DIR_ROWS] = '{
        // Tick and an unchanged sample right after reset.
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1,
          '{16'd0, qdsm_pkg::DIR_DOWN, 33'sd0, 1'b1}},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b0, 1'b0, 16'd0, 1'b1,
          '{16'd0, qdsm_pkg::DIR_DOWN, 33'sd0, 1'b0}},
        // One full forward cycle of channel 0, then a tick at the reset scale.
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b1, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b1, 1'b1, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b0, 1'b1, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b0, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1,
          '{16'd4, qdsm_pkg::DIR_UP, -33'sd10052, 1'b1}},
        // A backward step, then both phases changing in one sample.
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b0, 1'b1, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b1, 1'b0, 16'd0, 1'b0, NO_READING},
        // Channel 1 wraps below zero.
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b1, 1'b0, 1'b1, 16'd0, 1'b1,
          '{16'd65535, qdsm_pkg::DIR_DOWN, 33'sd0, 1'b0}},
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b1,
          '{16'd65535, qdsm_pkg::DIR_DOWN, 33'sd2513, 1'b1}},
        // Largest scale with the largest difference, counting down and then up.
        '{ROW_SCALE, qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b1, 1'b1, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b0, 1'b1, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b1, 1'b1, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1,
          '{16'd4, qdsm_pkg::DIR_DOWN, 33'sd4294836225, 1'b1}},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b1, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b0, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b0, 1'b1, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1,
          '{16'd3, qdsm_pkg::DIR_UP, -33'sd4294836225, 1'b1}},
        // Zero scale gives no speed at all.
        '{ROW_SCALE, qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b1, 1'b1, 1'b1, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b1,
          '{16'd65534, qdsm_pkg::DIR_DOWN, 33'sd0, 1'b1}},
        // Smallest nonzero scale; a net-zero double change ends counting up.
        '{ROW_SCALE, qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 1'b0, 16'd1, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_PIN,  1'b1, 1'b0, 1'b0, 16'd0, 1'b0, NO_READING},
        '{ROW_ITEM, qdsm_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, NO_READING}
    };

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                speed_scale_we;
    logic [qdsm_pkg::SCALE_W-1:0]        speed_scale_wdata;
    logic                                in_valid;
    logic                                in_ready;
    logic                                mode;
    logic [qdsm_pkg::CHANNEL_W-1:0]      channel;
    logic                                pin_a;
    logic                                pin_b;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [qdsm_pkg::POSITION_W-1:0]     position;
    logic                                direction;
    logic signed [qdsm_pkg::SPEED_W-1:0] speed;
    logic                                speed_valid;

    // Hand-typed result that goes with the item on the input port, if any.
    logic                  row_typed;
    reading_t              row_want;

    int                    stall_pct = 20;
    int                    err_count = 0;
    int                    results_seen = 0;
    reading_t              readings_due [$];

    // Decoder model state, one entry per channel.
    logic                  seen_a [2] = '{1'b0, 1'b0};
    logic                  seen_b [2] = '{1'b0, 1'b0};
    logic [15:0]           count_q [2] = '{16'd0, 16'd0};
    logic                  dir_q [2] = '{qdsm_pkg::DIR_DOWN, qdsm_pkg::DIR_DOWN};
    logic [15:0]           snap_q [2] = '{16'd0, 16'd0};
    logic [qdsm_pkg::SCALE_W-1:0] scale_q = qdsm_pkg::SCALE_RESET;

    // Stimulus side: last pin levels sent per channel as {a, b}.
    logic [1:0]            pins_now [2] = '{2'b00, 2'b00};

    quadrature_decoder_speed_meter u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .speed_scale_we    (speed_scale_we),
        .speed_scale_wdata (speed_scale_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .channel           (channel),
        .pin_a             (pin_a),
        .pin_b             (pin_b),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .position          (position),
        .direction         (direction),
        .speed             (speed),
        .speed_valid       (speed_valid)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random back-pressure on the result side.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Run guard.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic note_error(input string msg);
        $display("%0t ns  result %0d: %s", $realtime, results_seen, msg);
        err_count++;
    endtask

    // One x4 count step on a channel.
    function automatic void step_count(input logic [qdsm_pkg::CHANNEL_W-1:0] ch,
                                       input logic down);
        if (down)
        begin
            count_q[ch] = count_q[ch] - 16'd1;
            dir_q[ch]   = qdsm_pkg::DIR_DOWN;
        end
        else
        begin
            count_q[ch] = count_q[ch] + 16'd1;
            dir_q[ch]   = qdsm_pkg::DIR_UP;
        end
    endfunction

    // Decode one pin sample or measure speed on a tick; returns the expected result.
    function automatic reading_t decode_and_measure(input logic md,
                                                    input logic [qdsm_pkg::CHANNEL_W-1:0] ch,
                                                    input logic a, input logic b);
        reading_t    r;
        logic [15:0] diff;
        logic [32:0] mag;
        r.speed       = '0;
        r.speed_valid = 1'b0;
        if (md == qdsm_pkg::MODE_PIN)
        begin
            // A is applied before B when both change.
            if (a != seen_a[ch])
            begin
                seen_a[ch] = a;
                step_count(ch, a == b);
            end
            if (b != seen_b[ch])
            begin
                seen_b[ch] = b;
                step_count(ch, a != b);
            end
        end
        else
        begin
            // Travel since the last snapshot, measured in the last seen direction.
            if (dir_q[ch] == qdsm_pkg::DIR_DOWN)
                diff = snap_q[ch] - count_q[ch];
            else
                diff = count_q[ch] - snap_q[ch];
            mag = 33'(diff) * 33'(scale_q);
            r.speed       = (dir_q[ch] == qdsm_pkg::DIR_DOWN) ? mag : -mag;
            r.speed_valid = 1'b1;
            snap_q[ch]    = count_q[ch];
        end
        r.position  = count_q[ch];
        r.direction = dir_q[ch];
        return r;
    endfunction

    // Predict on every input transfer and compare every result transfer.
    always @(posedge clk)
    begin : scoreboard
        reading_t want;
        reading_t got;
        if (rst_n)
        begin
            if (speed_scale_we)
                scale_q = speed_scale_wdata;
            if (in_valid && in_ready)
            begin
                want = decode_and_measure(mode, channel, pin_a, pin_b);
                if (row_typed)
                    want = row_want;
                readings_due.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = '{position, direction, speed, speed_valid};
                if (readings_due.size() == 0)
                    note_error("result with no item waiting");
                else
                begin
                    want = readings_due.pop_front();
                    if (got.position !== want.position)
                        note_error($sformatf("position %0d, expected %0d",
                                             got.position, want.position));
                    if (got.direction !== want.direction)
                        note_error($sformatf("direction %b, expected %b",
                                             got.direction, want.direction));
                    if (got.speed !== want.speed)
                        note_error($sformatf("speed %0d, expected %0d",
                                             got.speed, want.speed));
                    if (got.speed_valid !== want.speed_valid)
                        note_error($sformatf("speed_valid %b, expected %b",
                                             got.speed_valid, want.speed_valid));
                end
                results_seen++;
            end
        end
    end

    // Present one item with random idle cycles ahead of it and wait for its transfer.
    task automatic send_item(input logic md, input logic [qdsm_pkg::CHANNEL_W-1:0] ch,
                             input logic a, input logic b,
                             input logic typed, input reading_t want);
        @(negedge clk);
        while ($urandom_range(99) < stall_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= md;
        channel   <= ch;
        pin_a     <= a;
        pin_b     <= b;
        row_typed <= typed;
        row_want  <= want;
        if (md == qdsm_pkg::MODE_PIN)
            pins_now[ch] = {a, b};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
    endtask

    // Scale writes happen only with nothing in flight.
    task automatic write_scale(input logic [qdsm_pkg::SCALE_W-1:0] value);
        drain();
        @(negedge clk);
        speed_scale_we    <= 1'b1;
        speed_scale_wdata <= value;
        @(negedge clk);
        speed_scale_we    <= 1'b0;
    endtask

    // Main sequence: reset, directed rows, then random phases at several scales.
    initial
    begin : stimulus
        logic [qdsm_pkg::SCALE_W-1:0]   phase_scale [PHASES];
        logic [1:0]                     up_seq [4];
        logic                           run_up [2];
        logic [qdsm_pkg::CHANNEL_W-1:0] cur_ch;
        logic [1:0]                     nxt;
        int                             pick;
        int                             idx;
        int                             n;

        phase_scale = '{qdsm_pkg::SCALE_RESET, 16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd0};
        phase_scale[3] = 16'($urandom);
        phase_scale[5] = 16'($urandom);
        // Forward quadrature order of {a, b}.
        up_seq = '{2'b00, 2'b10, 2'b11, 2'b01};
        run_up = '{1'b1, 1'b0};
        cur_ch = '0;
        n = 0;

        rst_n             = 1'b0;
        speed_scale_we    = 1'b0;
        speed_scale_wdata = '0;
        in_valid          = 1'b0;
        mode              = qdsm_pkg::MODE_PIN;
        channel           = '0;
        pin_a             = 1'b0;
        pin_b             = 1'b0;
        row_typed         = 1'b0;
        row_want          = NO_READING;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows.
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_SCALE)
                write_scale(dir_rows[r].scale);
            else
                send_item(dir_rows[r].mode, dir_rows[r].chan, dir_rows[r].a,
                          dir_rows[r].b, dir_rows[r].typed, dir_rows[r].want);
        end

        // Random phases: mostly clean quadrature walks with ticks, some noise.
        for (int p = 0; p < PHASES; p++)
        begin
            write_scale(phase_scale[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // A long stretch with no idling on either side.
                stall_pct = (n >= 200 && n < 400) ? 0 : 20;
                if (p == 2 && i == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(99) < 20)
                    cur_ch = qdsm_pkg::CHANNEL_W'($urandom_range(1));
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    nxt = 2'($urandom_range(3));
                    send_item(qdsm_pkg::MODE_TICK, cur_ch, nxt[1], nxt[0], 1'b0, NO_READING);
                end
                else
                begin
                    if (pick < 80)
                    begin
                        // Legal single-phase step in the current run direction.
                        if ($urandom_range(99) < 8)
                            run_up[cur_ch] = ~run_up[cur_ch];
                        idx = 0;
                        for (int k = 0; k < 4; k++)
                            if (up_seq[k] == pins_now[cur_ch])
                                idx = k;
                        nxt = up_seq[2'(idx + (run_up[cur_ch] ? 1 : 3))];
                    end
                    else if (pick < 90)
                        nxt = pins_now[cur_ch];
                    else
                        nxt = 2'($urandom_range(3));
                    send_item(qdsm_pkg::MODE_PIN, cur_ch, nxt[1], nxt[0], 1'b0, NO_READING);
                end
                n++;
            end
        end

        // Let the last results drain, then a few more cycles for anything stray.
        drain();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/qdsm_pkg.sv
hw/rtl/quadrature_decoder_speed_meter.sv
bench/testbench.sv
